// ===== hw/rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the RTL checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also checks across reset.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/rsdp_pkg.sv =====
// ---------------------------------------------------------------------------
// RSDP scanner package
// Signature table, check offsets and slot control type for the scanner.
// ---------------------------------------------------------------------------
package rsdp_pkg;

   localparam int SIG_LEN   = 8;
   localparam int SHORT_LEN = 20;
   localparam int LONG_LEN  = 36;
   localparam int REV_AT    = 15;
   localparam int COUNT_W   = 6;
   localparam int OFFSET_W  = 17;

   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [7:0]         byte_type;

   typedef struct packed {
      logic advance;
      logic clear;
      logic launch;
   } slot_ctl_type;

   // "RSD PTR "
   function automatic byte_type sig_byte(input logic [2:0] idx);
      byte_type b;
      unique case (idx)
         3'd0: b = 8'h52;
         3'd1: b = 8'h53;
         3'd2: b = 8'h44;
         3'd3: b = 8'h20;
         3'd4: b = 8'h50;
         3'd5: b = 8'h54;
         3'd6: b = 8'h52;
         3'd7: b = 8'h20;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

// ===== hw/rtl/rsdp_slot.sv =====
// ---------------------------------------------------------------------------
// RSDP candidate slot
// Tracks one candidate structure: signature, running checksum, revision.
// ---------------------------------------------------------------------------
module rsdp_slot import rsdp_pkg::*; #(
   parameter int POS_W = 18
) (
   input  logic             clock,
   input  logic             reset,
   input  slot_ctl_type     ctl,
   input  logic [POS_W-1:0] start_pos,
   input  byte_type         data_byte,
   input  byte_type         min_revision,
   output logic             hit,
   output logic [POS_W-1:0] hit_start
);

   logic             active_ff, active_in;
   count_type        count_ff, count_in;
   byte_type         sum_ff, sum_in;
   logic             sig_ff, sig_in;
   logic             short_ff, short_in;
   logic             rev_ff, rev_in;
   logic [POS_W-1:0] start_ff, start_in;

   logic      cur_active, cur_sig, cur_short, cur_rev;
   count_type cur_count;
   byte_type  cur_sum;
   logic      sig_mismatch, last_byte;

   always_comb begin
      // a launch restarts the slot on the byte that arrives with it
      cur_active = ctl.launch | active_ff;
      cur_count  = ctl.launch ? '0 : count_ff;
      cur_sum    = ctl.launch ? '0 : sum_ff;
      cur_sig    = ctl.launch | sig_ff;
      cur_short  = ctl.launch ? 1'b0 : short_ff;
      cur_rev    = ctl.launch ? 1'b0 : rev_ff;

      sig_mismatch = (cur_count < COUNT_W'(SIG_LEN)) &&
                     (data_byte != sig_byte(cur_count[2:0]));
      sum_in   = cur_sum + data_byte;
      sig_in   = cur_sig & ~sig_mismatch;
      rev_in   = (cur_count == COUNT_W'(REV_AT)) ? (data_byte >= min_revision) : cur_rev;
      short_in = (cur_count == COUNT_W'(SHORT_LEN - 1)) ? (sum_in == 8'd0) : cur_short;
      last_byte = (cur_count == COUNT_W'(LONG_LEN - 1));
      count_in  = cur_count + COUNT_W'(1);
      active_in = cur_active & ~last_byte;
      start_in  = ctl.launch ? start_pos : start_ff;

      hit = cur_active & last_byte & sig_in & short_in & rev_in & (sum_in == 8'd0);
      hit_start = start_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else if (ctl.clear) begin
         active_ff <= 1'b0;
      end else if (ctl.advance) begin
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.advance && cur_active) begin
         count_ff <= count_in;
         sum_ff   <= sum_in;
         sig_ff   <= sig_in;
         short_ff <= short_in;
         rev_ff   <= rev_in;
         start_ff <= start_in;
      end
   end

endmodule

// ===== hw/rtl/rsdp_pointer_scanner.sv =====
// ---------------------------------------------------------------------------
// RSDP pointer scanner
// Scans a byte stream for a valid root-pointer structure and reports it.
// ---------------------------------------------------------------------------
// Takes one byte per clock, back to back, while not stalled, with no clearing pass after reset.
// A request is held in the input register; the checks of all candidate
// slots run in the cycle it leaves, and the response is held in the output
// register, so a response shows after its request has passed the input and
// then the output register. The input register keeps taking requests while
// a response waits; the stream stalls only when both registers are full.
// Candidates start every SCAN_STEP bytes, ceil(36 / SCAN_STEP) of them run
// in parallel slots, and a response comes for the byte that completes the
// first passing candidate or for the region's last byte when none passed.
module rsdp_pointer_scanner import rsdp_pkg::*; #(
   parameter int MAX_REGION_BYTES = 131072,
   parameter int SCAN_STEP        = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_data_byte,
   input  logic                req_region_end,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_found,
   output logic [OFFSET_W-1:0] rsp_match_offset,
   input  logic                csr_wr_en,
   input  logic [7:0]          csr_wr_data
);

   localparam int SLOTS  = (LONG_LEN + SCAN_STEP - 1) / SCAN_STEP;
   localparam int POS_W  = $clog2(MAX_REGION_BYTES + 1);
   localparam int PH_W   = $clog2(SCAN_STEP);
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   logic                in_valid_ff, in_valid_in;
   byte_type            in_data_ff;
   logic                in_end_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_found_ff;
   logic [OFFSET_W-1:0] rsp_offset_ff;
   byte_type            min_rev_ff;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [PH_W-1:0]     phase_ff, phase_in;
   logic [SLOT_W-1:0]   ptr_ff, ptr_in;
   logic                done_ff, done_in;

   logic                accept, advance, step, emit, launch_ok, pos_open;
   logic                hit_any;
   logic [POS_W-1:0]    hit_off;
   logic [POS_W+OFFSET_W-1:0] off_ext;
   logic [OFFSET_W-1:0] offset_in;

   slot_ctl_type        slot_ctl [SLOTS];
   logic                slot_hit [SLOTS];
   logic [POS_W-1:0]    slot_start [SLOTS];

   assign accept    = req_valid & req_ready;
   assign pos_open  = pos_ff < POS_W'(MAX_REGION_BYTES);
   assign launch_ok = ~done_ff & pos_open & (phase_ff == '0);

   generate
      for (genvar s = 0; s < SLOTS; s++) begin : g_slot
         assign slot_ctl[s].advance = step;
         assign slot_ctl[s].clear   = advance & in_end_ff;
         assign slot_ctl[s].launch  = launch_ok & (ptr_ff == SLOT_W'(s));

         rsdp_slot #(
            .POS_W (POS_W)
         ) u_slot (
            .clock        (clock),
            .reset        (reset),
            .ctl          (slot_ctl[s]),
            .start_pos    (pos_ff),
            .data_byte    (in_data_ff),
            .min_revision (min_rev_ff),
            .hit          (slot_hit[s]),
            .hit_start    (slot_start[s])
         );
      end
   endgenerate

   // lowest slot wins; at most one slot completes per byte anyway
   always_comb begin
      hit_any = 1'b0;
      hit_off = '0;
      for (int s = 0; s < SLOTS; s++) begin
         if (!hit_any && slot_hit[s]) begin
            hit_any = 1'b1;
            hit_off = slot_start[s];
         end
      end
   end

   always_comb begin
      emit    = ~done_ff & (hit_any | in_end_ff);
      advance = in_valid_ff & (~emit | ~rsp_valid_ff | rsp_ready);
      step    = advance & ~done_ff;
      req_ready = ~in_valid_ff | advance;

      off_ext   = {{OFFSET_W{1'b0}}, hit_off};
      offset_in = hit_any ? off_ext[OFFSET_W-1:0] : '0;

      in_valid_in = accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);

      priority if (advance && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      pos_in   = pos_ff;
      phase_in = phase_ff;
      ptr_in   = ptr_ff;
      done_in  = done_ff;
      priority if (advance && in_end_ff) begin
         // start a fresh region
         pos_in   = '0;
         phase_in = '0;
         ptr_in   = '0;
         done_in  = 1'b0;
      end else if (step) begin
         if (pos_open) begin
            pos_in = pos_ff + POS_W'(1);
         end
         phase_in = (phase_ff == PH_W'(SCAN_STEP - 1)) ? '0 : phase_ff + PH_W'(1);
         if (launch_ok) begin
            ptr_in = (ptr_ff == SLOT_W'(SLOTS - 1)) ? '0 : ptr_ff + SLOT_W'(1);
         end
         done_in = hit_any;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         min_rev_ff   <= 8'd2;
         pos_ff       <= '0;
         phase_ff     <= '0;
         ptr_ff       <= '0;
         done_ff      <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            min_rev_ff <= csr_wr_data;
         end
         pos_ff   <= pos_in;
         phase_ff <= phase_in;
         ptr_ff   <= ptr_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_data_byte;
         in_end_ff  <= req_region_end;
      end
      if (advance && emit) begin
         rsp_found_ff  <= hit_any;
         rsp_offset_ff <= offset_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_match_offset = rsp_offset_ff;

endmodule

// ===== hw/rtl/rsdp_checker.sv =====
// ---------------------------------------------------------------------------
// RSDP scanner checker
// Port-level assertions for the pointer scanner, bound to the scanner module.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rsdp_checker import rsdp_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic                rsp_found,
   input logic [OFFSET_W-1:0] rsp_match_offset
);

   // hold a pending response until it is taken
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "response dropped")

   // a not-found response carries a zero offset
   `ASSERT_CLK(a_nf_zero, clock, reset, rsp_valid && !rsp_found |-> rsp_match_offset == '0, "offset not zero")

   // with the output register empty the scanner always takes a request
   `ASSERT_CLK(a_ready_free, clock, reset, !rsp_valid |-> req_ready, "stalled with empty output")

   // no response straight out of reset
   `ASSERT_CLK_ALWAYS(a_rst_quiet, clock, reset |=> !rsp_valid, "response after reset")

   // a request passes the input register and then the output register before it reaches the output
   `ASSERT_CLK(a_min_latency, clock, reset, $rose(rsp_valid) |-> !$past(reset) && !$past(reset, 2), "response too early")

endmodule

bind rsdp_pointer_scanner rsdp_checker u_rsdp_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_found        (rsp_found),
   .rsp_match_offset (rsp_match_offset)
);
